// ===== sv/sbrc_pkg.sv =====
package sbrc_pkg;

	localparam int NUM_REGS = 8;
	localparam int LANES = 4;

	// widths of the intermediate values
	localparam int EDGE_W = 17;
	localparam int SW_W = 33;
	localparam int DW_W = 17;
	localparam int BP_W = 50;
	localparam int BN_W = 53;
	localparam int BD_W = 17;
	localparam int BQ_W = 33;
	localparam int FV_W = 51;
	localparam int FN_W = 52;
	localparam int FD_W = 33;
	localparam int FQ_W = 18;
	localparam int SUM_W = 35;
	localparam int AW = 20;

	typedef enum logic [2:0] {
		REG_SRC_LEFT   = 3'd0,
		REG_SRC_TOP    = 3'd1,
		REG_SRC_RIGHT  = 3'd2,
		REG_SRC_BOTTOM = 3'd3,
		REG_DST_LEFT   = 3'd4,
		REG_DST_TOP    = 3'd5,
		REG_DST_RIGHT  = 3'd6,
		REG_DST_BOTTOM = 3'd7
	} reg_idx_t;

	typedef logic signed [15:0] pix_t;
	typedef logic signed [31:0] fix_t;

	typedef struct packed {
		fix_t src_left;
		fix_t src_top;
		fix_t src_right;
		fix_t src_bottom;
		pix_t dst_left;
		pix_t dst_top;
		pix_t dst_right;
		pix_t dst_bottom;
	} req_t;

	typedef struct packed {
		fix_t out_src_left;
		fix_t out_src_top;
		fix_t out_src_right;
		fix_t out_src_bottom;
		pix_t out_dst_left;
		pix_t out_dst_top;
		pix_t out_dst_right;
		pix_t out_dst_bottom;
		logic degenerate;
	} rsp_t;

	typedef struct packed {
		fix_t s0;
		pix_t d0;
		logic signed [SW_W-1:0] sw;
		logic signed [DW_W-1:0] dw;
	} axis_t;

	typedef struct packed {
		axis_t [1:0] ax;
		pix_t [LANES-1:0] od;
		logic deg;
	} ctx_t;

	localparam int CTX_W = $bits(ctx_t);

endpackage

// ===== sv/sbrc_if.sv =====
interface sbrc_req_if;
	import sbrc_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sbrc_rsp_if;
	import sbrc_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sbrc_cfg_if;
	import sbrc_pkg::*;
	logic valid;
	logic ready;
	reg_idx_t idx;
	logic [15:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== sv/sbrc_div.sv =====
module sbrc_div #(
	parameter int LANES = 4,
	parameter int NW = 53,
	parameter int DW = 17,
	parameter int QW = 33,
	parameter int TW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [NW-1:0] num [LANES],
	input  logic [DW-1:0] den [LANES],
	input  logic [TW-1:0] in_tag,
	output logic out_valid,
	output logic signed [QW:0] quo [LANES],
	output logic [TW-1:0] out_tag
);
	// floor division, one quotient bit per stage, quotient saturated to QW bits
	localparam int RW = DW + QW;
	localparam int MW = NW - 1;
	localparam int CW = (MW > RW) ? MW : RW;

	logic valid_s [QW+1];
	logic [TW-1:0] tag_s [QW+1];
	logic [RW-1:0] rem_s [QW+1][LANES];
	logic [DW-1:0] den_s [QW+1][LANES];
	logic [QW-1:0] quo_s [QW+1][LANES];
	logic neg_s [QW+1][LANES];
	logic sat_s [QW+1][LANES];

	logic neg_c [LANES];
	logic [MW-1:0] mag_c [LANES];
	logic sat_c [LANES];

	// negative numerators divide their complement, the quotient is complemented back
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			neg_c[l] = num[l][NW-1];
			mag_c[l] = neg_c[l] ? ~num[l][MW-1:0] : num[l][MW-1:0];
			sat_c[l] = CW'(mag_c[l]) >= (CW'(den[l]) << QW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= sat_c[l] ? '0 : RW'(mag_c[l]);
				den_s[0][l] <= den[l];
				quo_s[0][l] <= '0;
				neg_s[0][l] <= neg_c[l];
				sat_s[0][l] <= sat_c[l];
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] trial [LANES];
		logic fit [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = RW'(den_s[k][l]) << (QW - 1 - k);
				fit[l] = rem_s[k][l] >= trial[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= fit[l] ? rem_s[k][l] - trial[l] : rem_s[k][l];
					den_s[k+1][l] <= den_s[k][l];
					quo_s[k+1][l] <= (quo_s[k][l] << 1) | QW'(fit[l]);
					neg_s[k+1][l] <= neg_s[k][l];
					sat_s[k+1][l] <= sat_s[k][l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (neg_s[QW][l]) begin
				quo[l] = sat_s[QW][l] ? ~{1'b0, {QW{1'b1}}} : ~{1'b0, quo_s[QW][l]};
			end else begin
				quo[l] = sat_s[QW][l] ? {1'b0, {QW{1'b1}}} : {1'b0, quo_s[QW][l]};
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign out_tag = tag_s[QW];

endmodule

// ===== sv/sbrc_bmap.sv =====
module sbrc_bmap (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [sbrc_pkg::EDGE_W-1:0] e [sbrc_pkg::LANES],
	input  sbrc_pkg::ctx_t in_ctx,
	input  sbrc_pkg::pix_t sb_lo [2],
	input  sbrc_pkg::pix_t sb_hi [2],
	output logic out_valid,
	output sbrc_pkg::fix_t n [sbrc_pkg::LANES],
	output sbrc_pkg::ctx_t out_ctx
);
	import sbrc_pkg::*;

	// back map: s0 + round((p - d0) * sw / dw), then clamp to the source surface
	logic valid_s1, valid_s2, valid_s3;
	ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic signed [BP_W-1:0] prod_c [LANES];
	logic signed [BP_W-1:0] prod_s1 [LANES];
	logic signed [BN_W-1:0] num_c [LANES];
	logic [BD_W-1:0] den_c [LANES];
	logic signed [BN_W-1:0] num_s2 [LANES];
	logic [BD_W-1:0] den_s2 [LANES];
	logic div_valid;
	ctx_t div_ctx;
	logic signed [BQ_W:0] div_q [LANES];
	logic signed [SUM_W-1:0] r_c [LANES];
	fix_t n_s3 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_c[l] = e[l] * in_ctx.ax[l/2].sw;
		end
	end

	always_comb begin
		logic signed [DW_W-1:0] absd;
		logic signed [BN_W-1:0] nv;
		for (int l = 0; l < LANES; l++) begin
			absd = ctx_s1.ax[l/2].dw[DW_W-1] ? -ctx_s1.ax[l/2].dw : ctx_s1.ax[l/2].dw;
			nv = ctx_s1.ax[l/2].dw[DW_W-1] ? -BN_W'(prod_s1[l]) : BN_W'(prod_s1[l]);
			// rounding to nearest: floor((2 num + den) / (2 den))
			num_c[l] = (nv <<< 1) + BN_W'(absd[DW_W-2:0]);
			den_c[l] = {absd[DW_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= in_ctx;
			ctx_s2 <= ctx_s1;
			ctx_s3 <= div_ctx;
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= prod_c[l];
				num_s2[l] <= num_c[l];
				den_s2[l] <= den_c[l];
				n_s3[l] <= r_c[l][31:0];
			end
		end
	end

	sbrc_div #(
		.LANES(LANES),
		.NW(BN_W),
		.DW(BD_W),
		.QW(BQ_W),
		.TW(CTX_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s2),
		.num(num_s2),
		.den(den_s2),
		.in_tag(ctx_s2),
		.out_valid(div_valid),
		.quo(div_q),
		.out_tag(div_ctx)
	);

	always_comb begin
		logic signed [SUM_W-1:0] lo, hi;
		for (int l = 0; l < LANES; l++) begin
			lo = SUM_W'($signed({sb_lo[l/2], 16'h0000}));
			hi = SUM_W'($signed({sb_hi[l/2], 16'h0000}));
			r_c[l] = SUM_W'(div_ctx.ax[l/2].s0) + SUM_W'(div_q[l]);
			if (r_c[l] < lo) begin
				r_c[l] = lo;
			end
			if (r_c[l] > hi) begin
				r_c[l] = hi;
			end
		end
	end

	assign out_valid = valid_s3;
	assign n = n_s3;
	assign out_ctx = ctx_s3;

endmodule

// ===== sv/sbrc_fmap.sv =====
module sbrc_fmap (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sbrc_pkg::fix_t n [sbrc_pkg::LANES],
	input  sbrc_pkg::ctx_t in_ctx,
	input  sbrc_pkg::pix_t db_lo [2],
	input  sbrc_pkg::pix_t db_hi [2],
	output logic out_valid,
	output logic signed [sbrc_pkg::EDGE_W-1:0] e [sbrc_pkg::LANES],
	output sbrc_pkg::ctx_t out_ctx
);
	import sbrc_pkg::*;

	// forward map, interior integer area, clamp to the destination surface
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic signed [SW_W-1:0] f_s1 [LANES];
	logic signed [BP_W-1:0] prod_c [LANES];
	logic signed [BP_W-1:0] prod_s2 [LANES];
	logic signed [FN_W-1:0] num_c [LANES];
	logic [FD_W-1:0] den_c [LANES];
	logic signed [FN_W-1:0] num_s3 [LANES];
	logic [FD_W-1:0] den_s3 [LANES];
	logic div_valid;
	ctx_t div_ctx;
	logic signed [FQ_W:0] div_q [LANES];
	logic signed [AW-1:0] a_c [LANES];
	pix_t a_s4 [LANES];
	logic signed [EDGE_W-1:0] e_s5 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_c[l] = f_s1[l] * ctx_s1.ax[l/2].dw;
		end
	end

	// lane 2x is the low edge (negated for a ceiling), lane 2x+1 the high edge
	always_comb begin
		logic signed [FV_W-1:0] m0, m1, v0, v1, w0, w1;
		logic signed [SW_W-1:0] asw;
		logic sneg, swap;
		for (int x = 0; x < 2; x++) begin
			sneg = ctx_s2.ax[x].sw[SW_W-1];
			m0 = -FV_W'(prod_s2[2*x]);
			m1 = -FV_W'(prod_s2[2*x+1]);
			v0 = sneg ? m0 : FV_W'(prod_s2[2*x]);
			v1 = sneg ? m1 : FV_W'(prod_s2[2*x+1]);
			w0 = sneg ? FV_W'(prod_s2[2*x]) : m0;
			w1 = sneg ? FV_W'(prod_s2[2*x+1]) : m1;
			swap = v0 > v1;
			num_c[2*x] = swap ? FN_W'(w1) : FN_W'(w0);
			num_c[2*x+1] = swap ? FN_W'(v0) : FN_W'(v1);
			asw = sneg ? -ctx_s2.ax[x].sw : ctx_s2.ax[x].sw;
			den_c[2*x] = asw;
			den_c[2*x+1] = asw;
		end
	end

	always_comb begin
		logic signed [AW-1:0] lo, hi;
		for (int l = 0; l < LANES; l++) begin
			lo = AW'(db_lo[l/2]);
			hi = AW'(db_hi[l/2]);
			if (l % 2 == 0) begin
				a_c[l] = AW'(div_ctx.ax[l/2].d0) - AW'(div_q[l]);
			end else begin
				a_c[l] = AW'(div_ctx.ax[l/2].d0) + AW'(div_q[l]) + AW'(1);
			end
			if (a_c[l] < lo) begin
				a_c[l] = lo;
			end
			if (a_c[l] > hi) begin
				a_c[l] = hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= div_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= in_ctx;
			ctx_s2 <= ctx_s1;
			ctx_s3 <= ctx_s2;
			ctx_s4 <= div_ctx;
			ctx_s5.ax <= ctx_s4.ax;
			ctx_s5.deg <= ctx_s4.deg;
			for (int l = 0; l < LANES; l++) begin
				f_s1[l] <= SW_W'(n[l]) - SW_W'(in_ctx.ax[l/2].s0);
				prod_s2[l] <= prod_c[l];
				num_s3[l] <= num_c[l];
				den_s3[l] <= den_c[l];
				a_s4[l] <= a_c[l][15:0];
				e_s5[l] <= EDGE_W'(a_s4[l]) - EDGE_W'(ctx_s4.ax[l/2].d0);
				ctx_s5.od[l] <= a_s4[l];
			end
		end
	end

	sbrc_div #(
		.LANES(LANES),
		.NW(FN_W),
		.DW(FD_W),
		.QW(FQ_W),
		.TW(CTX_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s3),
		.num(num_s3),
		.den(den_s3),
		.in_tag(ctx_s3),
		.out_valid(div_valid),
		.quo(div_q),
		.out_tag(div_ctx)
	);

	assign out_valid = valid_s5;
	assign e = e_s5;
	assign out_ctx = ctx_s5;

endmodule

// ===== sv/scaled_blit_rect_clipper.sv =====
// channel | role | handshake     | payload
// cfg     | sink | valid / ready | idx (register index), wdata (16 bit)
// req     | sink | valid / ready | source rect Q16.16, destination area integer
// rsp     | src  | valid / ready | clipped source rect, clipped area, degenerate
//
// one item enters per cycle while no result waits on rsp; the pipeline holds the three
// bit-per-stage dividers (33 + 18 + 33 quotient bits) and their set-up stages
// arst_n clears all valid bits and the configuration registers to zero
// a result held on rsp freezes the whole pipeline; req.ready drops with it
// cfg is always ready; write it only while no item is in flight, the block does not enforce it
module scaled_blit_rect_clipper (
	input logic clk,
	input logic arst_n,
	sbrc_cfg_if.sink cfg,
	sbrc_req_if.sink req,
	sbrc_rsp_if.source rsp
);
	import sbrc_pkg::*;

	// surface bounds
	pix_t cfg_q [NUM_REGS];
	pix_t sb_lo [2], sb_hi [2], db_lo [2], db_hi [2];

	// pipeline moves as one; only a waiting result stops it
	logic en;

	logic valid_s1, valid_s2;
	req_t req_s1;
	ctx_t ctx_c, ctx_s2;
	logic signed [EDGE_W-1:0] e_c [LANES];
	logic signed [EDGE_W-1:0] e_s2 [LANES];

	logic a_valid, f_valid, c_valid;
	fix_t a_n [LANES];
	fix_t c_n [LANES];
	ctx_t a_ctx, f_ctx, c_ctx;
	logic signed [EDGE_W-1:0] f_e [LANES];

	logic out_valid_q;
	rsp_t out_q;
	rsp_t out_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			cfg_q[cfg.idx] <= cfg.wdata;
		end
	end

	assign sb_lo[0] = cfg_q[REG_SRC_LEFT];
	assign sb_lo[1] = cfg_q[REG_SRC_TOP];
	assign sb_hi[0] = cfg_q[REG_SRC_RIGHT];
	assign sb_hi[1] = cfg_q[REG_SRC_BOTTOM];
	assign db_lo[0] = cfg_q[REG_DST_LEFT];
	assign db_lo[1] = cfg_q[REG_DST_TOP];
	assign db_hi[0] = cfg_q[REG_DST_RIGHT];
	assign db_hi[1] = cfg_q[REG_DST_BOTTOM];

	assign en = !out_valid_q || rsp.ready;
	assign req.ready = en;

	// set-up: extents, zero-divisor flag, destination area clamped to the surface
	always_comb begin
		pix_t dv [LANES];
		pix_t c;
		dv[0] = req_s1.dst_left;
		dv[1] = req_s1.dst_right;
		dv[2] = req_s1.dst_top;
		dv[3] = req_s1.dst_bottom;
		ctx_c.ax[0].s0 = req_s1.src_left;
		ctx_c.ax[0].d0 = req_s1.dst_left;
		ctx_c.ax[0].sw = SW_W'(req_s1.src_right) - SW_W'(req_s1.src_left);
		ctx_c.ax[0].dw = DW_W'(req_s1.dst_right) - DW_W'(req_s1.dst_left);
		ctx_c.ax[1].s0 = req_s1.src_top;
		ctx_c.ax[1].d0 = req_s1.dst_top;
		ctx_c.ax[1].sw = SW_W'(req_s1.src_bottom) - SW_W'(req_s1.src_top);
		ctx_c.ax[1].dw = DW_W'(req_s1.dst_bottom) - DW_W'(req_s1.dst_top);
		ctx_c.od = '0;
		ctx_c.deg = (req_s1.src_right == req_s1.src_left)
			|| (req_s1.src_bottom == req_s1.src_top)
			|| (req_s1.dst_right == req_s1.dst_left)
			|| (req_s1.dst_bottom == req_s1.dst_top);
		for (int l = 0; l < LANES; l++) begin
			c = dv[l];
			if (c < db_lo[l/2]) begin
				c = db_lo[l/2];
			end
			if (c > db_hi[l/2]) begin
				c = db_hi[l/2];
			end
			e_c[l] = EDGE_W'(c) - EDGE_W'(dv[2*(l/2)]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			out_valid_q <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= req.data;
			ctx_s2 <= ctx_c;
			e_s2 <= e_c;
			out_q <= out_c;
		end
	end

	// first back map of the clamped destination area
	sbrc_bmap u_bmap_a (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s2),
		.e(e_s2),
		.in_ctx(ctx_s2),
		.sb_lo(sb_lo),
		.sb_hi(sb_hi),
		.out_valid(a_valid),
		.n(a_n),
		.out_ctx(a_ctx)
	);

	// forward map and interior integer area
	sbrc_fmap u_fmap (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(a_valid),
		.n(a_n),
		.in_ctx(a_ctx),
		.db_lo(db_lo),
		.db_hi(db_hi),
		.out_valid(f_valid),
		.e(f_e),
		.out_ctx(f_ctx)
	);

	// final back map gives the source rectangle
	sbrc_bmap u_bmap_c (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(f_valid),
		.e(f_e),
		.in_ctx(f_ctx),
		.sb_lo(sb_lo),
		.sb_hi(sb_hi),
		.out_valid(c_valid),
		.n(c_n),
		.out_ctx(c_ctx)
	);

	// degenerate items report zeros and the flag
	always_comb begin
		out_c = '0;
		out_c.degenerate = c_ctx.deg;
		if (!c_ctx.deg) begin
			out_c.out_src_left = c_n[0];
			out_c.out_src_right = c_n[1];
			out_c.out_src_top = c_n[2];
			out_c.out_src_bottom = c_n[3];
			out_c.out_dst_left = c_ctx.od[0];
			out_c.out_dst_right = c_ctx.od[1];
			out_c.out_dst_top = c_ctx.od[2];
			out_c.out_dst_bottom = c_ctx.od[3];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.degenerate |-> out_q.out_src_left == '0
			&& out_q.out_dst_right == '0 && out_q.out_src_bottom == '0)
		else $error("degenerate item carries non-zero fields");

	a_dst_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.degenerate |->
			out_q.out_dst_right <= cfg_q[REG_DST_RIGHT]
			&& out_q.out_dst_bottom <= cfg_q[REG_DST_BOTTOM])
		else $error("destination area beyond the surface");

	a_src_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.degenerate |->
			out_q.out_src_right <= $signed({cfg_q[REG_SRC_RIGHT], 16'h0000})
			&& out_q.out_src_bottom <= $signed({cfg_q[REG_SRC_BOTTOM], 16'h0000}))
		else $error("source rectangle beyond the surface");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import sbrc_pkg::*;

// scoreboard: keeps the surface bounds, predicts each clipped blit and
// compares it with what comes out of the block
class blit_scoreboard;
	logic signed [15:0] bounds [NUM_REGS];
	rsp_t pending [$];
	int mismatches;
	int checked;
	int degenerate_seen;

	function new();
		foreach (bounds[i]) bounds[i] = '0;
		mismatches = 0;
		checked = 0;
		degenerate_seen = 0;
	endfunction

	// floor division for a positive divisor
	function longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	// source edge for destination edge p, nearest step, halves upwards
	function longint map_back(longint p, longint a0, longint aw, longint s0, longint sw);
		longint num;
		longint den;
		num = (p - a0) * sw;
		den = aw;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		return s0 + floor_div(2 * num + den, 2 * den);
	endfunction

	function void clamp(inout longint a, inout longint b, input longint lo, input longint hi);
		if (a < lo) a = lo;
		if (b < lo) b = lo;
		if (a > hi) a = hi;
		if (b > hi) b = hi;
	endfunction

	function void clip_axis(input longint s0, s1, d0, d1, sb0, sb1, db0, db1,
			output longint os0, os1, od0, od1);
		longint sw, dw, c0, c1, n0, n1, lo, hi, den, t;
		sw = s1 - s0;
		dw = d1 - d0;
		c0 = d0;
		c1 = d1;
		clamp(c0, c1, db0, db1);
		n0 = map_back(c0, d0, dw, s0, sw);
		n1 = map_back(c1, d0, dw, s0, sw);
		clamp(n0, n1, sb0 * 65536, sb1 * 65536);
		// forward mapping stays exact, interior taken of the quotient
		lo = (n0 - s0) * dw;
		hi = (n1 - s0) * dw;
		den = sw;
		if (den < 0) begin
			lo = -lo;
			hi = -hi;
			den = -den;
		end
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		od0 = d0 - floor_div(-lo, den);
		od1 = d0 + floor_div(hi, den) + 1;
		clamp(od0, od1, db0, db1);
		os0 = map_back(od0, d0, dw, s0, sw);
		os1 = map_back(od1, d0, dw, s0, sw);
		clamp(os0, os1, sb0 * 65536, sb1 * 65536);
	endfunction

	function void note_request(req_t r);
		rsp_t e;
		longint a, b, c, d;
		e = '0;
		if (r.src_right == r.src_left || r.src_bottom == r.src_top
				|| r.dst_right == r.dst_left || r.dst_bottom == r.dst_top) begin
			e.degenerate = 1'b1;
		end else begin
			clip_axis(longint'(r.src_left), longint'(r.src_right),
				longint'(r.dst_left), longint'(r.dst_right),
				longint'(bounds[REG_SRC_LEFT]), longint'(bounds[REG_SRC_RIGHT]),
				longint'(bounds[REG_DST_LEFT]), longint'(bounds[REG_DST_RIGHT]),
				a, b, c, d);
			e.out_src_left = a[31:0];
			e.out_src_right = b[31:0];
			e.out_dst_left = c[15:0];
			e.out_dst_right = d[15:0];
			clip_axis(longint'(r.src_top), longint'(r.src_bottom),
				longint'(r.dst_top), longint'(r.dst_bottom),
				longint'(bounds[REG_SRC_TOP]), longint'(bounds[REG_SRC_BOTTOM]),
				longint'(bounds[REG_DST_TOP]), longint'(bounds[REG_DST_BOTTOM]),
				a, b, c, d);
			e.out_src_top = a[31:0];
			e.out_src_bottom = b[31:0];
			e.out_dst_top = c[15:0];
			e.out_dst_bottom = d[15:0];
		end
		pending.push_back(e);
	endfunction

	function void check_result(rsp_t got);
		rsp_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("result with nothing expected: %p", got);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (e.degenerate) degenerate_seen++;
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d differs\n  expected %p\n  actual   %p", checked, e, got);
		end
	endfunction
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit quiet = 1'b0;
	int items_sent = 0;
	blit_scoreboard sb = new();

	sbrc_cfg_if cfg_if ();
	sbrc_req_if req_if ();
	sbrc_rsp_if rsp_if ();

	scaled_blit_rect_clipper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #5 clk = ~clk;

	// hard limit on the run
	initial begin
		#5000000;
		$display("scaled_blit_rect_clipper: mismatch");
		$finish;
	end

	// result side: check accepted items, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
			rsp_if.ready <= quiet || ($urandom_range(99) >= 21);
		end
	end

	function bit roll_idle();
		return !quiet && ($urandom_range(99) < 21);
	endfunction

	task automatic write_bound(reg_idx_t idx, int v);
		cfg_if.valid <= 1'b1;
		cfg_if.idx <= idx;
		cfg_if.wdata <= v[15:0];
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.bounds[idx] = v[15:0];
	endtask

	// block must be empty before the bounds move
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_bounds(int sl, int st, int sr, int sbt, int dl, int dt, int dr, int db);
		drain();
		write_bound(REG_SRC_LEFT, sl);
		write_bound(REG_SRC_TOP, st);
		write_bound(REG_SRC_RIGHT, sr);
		write_bound(REG_SRC_BOTTOM, sbt);
		write_bound(REG_DST_LEFT, dl);
		write_bound(REG_DST_TOP, dt);
		write_bound(REG_DST_RIGHT, dr);
		write_bound(REG_DST_BOTTOM, db);
		cfg_if.valid <= 1'b0;
	endtask

	// valid stays high from one item to the next unless an idle cycle falls between
	task automatic send_blit(req_t r);
		while (roll_idle()) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_request(r);
		items_sent++;
	endtask

	task automatic send_edges(int sl, int st, int sr, int sbt, int dl, int dt, int dr, int db);
		req_t r;
		r.src_left = sl;
		r.src_top = st;
		r.src_right = sr;
		r.src_bottom = sbt;
		r.dst_left = dl[15:0];
		r.dst_top = dt[15:0];
		r.dst_right = dr[15:0];
		r.dst_bottom = db[15:0];
		send_blit(r);
	endtask

	// one edge pair near a bounds pair, mostly sensible, sometimes inverted
	function automatic void near_pair(int b0, int b1, bit fixp, output int e0, output int e1);
		int span;
		int t;
		span = (b1 > b0 ? b1 - b0 : b0 - b1) + 8;
		if (span > 2000) span = 2000;
		e0 = b0 + $signed($urandom_range(2 * span)) - span / 2;
		e1 = e0 + 1 + $urandom_range(span);
		if ($urandom_range(9) == 0) begin
			t = e0;
			e0 = e1;
			e1 = t;
		end
		if (fixp) begin
			e0 = e0 * 65536 + $signed($urandom_range(131071)) - 65536;
			e1 = e1 * 65536 + $signed($urandom_range(131071)) - 65536;
			if ($urandom_range(7) == 0) e1 = e0 + $signed($urandom_range(7)) - 3;
		end
	endfunction

	task automatic send_random_blit();
		req_t r;
		int a, b, c, d, e, f, g, h;
		if ($urandom_range(99) < 25) begin
			// raw noise over every bit of every field
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			send_blit(r);
		end else begin
			near_pair(int'(sb.bounds[REG_SRC_LEFT]), int'(sb.bounds[REG_SRC_RIGHT]), 1, a, c);
			near_pair(int'(sb.bounds[REG_SRC_TOP]), int'(sb.bounds[REG_SRC_BOTTOM]), 1, b, d);
			near_pair(int'(sb.bounds[REG_DST_LEFT]), int'(sb.bounds[REG_DST_RIGHT]), 0, e, g);
			near_pair(int'(sb.bounds[REG_DST_TOP]), int'(sb.bounds[REG_DST_BOTTOM]), 0, f, h);
			send_edges(a, b, c, d, e, f, g, h);
		end
	endtask

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.idx = REG_SRC_LEFT;
		cfg_if.wdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds: everything collapses onto the origin
		send_edges(32'sh0001_8000, 32'sh0000_4000, 32'sh0010_0000, 32'sh0008_0000,
			-5, -5, 20, 20);

		// ordinary surfaces, directed cases
		set_bounds(0, 0, 640, 480, 0, 0, 320, 240);
		// plain 2:1 downscale
		send_edges(0, 0, 640 << 16, 480 << 16, 0, 0, 320, 240);
		// each zero divisor
		send_edges(100 << 16, 0, 100 << 16, 480 << 16, 0, 0, 320, 240);
		send_edges(0, 7 << 16, 640 << 16, 7 << 16, 0, 0, 320, 240);
		send_edges(0, 0, 640 << 16, 480 << 16, 9, 0, 9, 240);
		send_edges(0, 0, 640 << 16, 480 << 16, 0, 3, 320, 3);
		// fractional source with halves, destination partly off surface
		send_edges(32'sh0000_8000, 32'sh0001_8000, 32'sh0100_8000, 32'sh00C0_8000,
			-40, -30, 300, 260);
		// inverted source and inverted destination
		send_edges(640 << 16, 480 << 16, 0, 0, 0, 0, 320, 240);
		send_edges(0, 0, 640 << 16, 480 << 16, 320, 240, 0, 0);
		// upscale, far outside the source
		send_edges(-(100 << 16), -(90 << 16), -(60 << 16), -(70 << 16), 0, 0, 320, 240);
		// field extremes
		send_edges(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			-32768, -32768, 32767, 32767);
		send_edges(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000, 32'shFFFF_FFFF,
			32767, 1, -32768, -1);
		send_edges(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh0000_0001, 32'sh0000_0003,
			0, 0, 1, 1);

		// widest surfaces
		set_bounds(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
		send_edges(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			-32768, -32768, 32767, 32767);
		send_edges(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32767, -32768, -32768, 32767);
		send_edges(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 32'sh0000_0005,
			-32768, 0, 32767, 3);
		repeat (150) send_random_blit();

		// inverted bounds are not reordered
		set_bounds(200, 100, -50, -20, 100, 80, 10, 5);
		send_edges(0, 0, 150 << 16, 90 << 16, 0, 0, 120, 90);
		repeat (120) send_random_blit();

		// random surfaces, one stretch without any idling
		set_bounds($signed($urandom_range(200)) - 100, 0, 900, $urandom_range(1000),
			-20, $signed($urandom_range(40)) - 20, 333, 201);
		quiet = 1'b1;
		repeat (120) send_random_blit();
		quiet = 1'b0;
		// sender holds off until the block has emptied
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) send_random_blit();

		// narrow surfaces, mostly clipped away
		set_bounds(-3, 5, 4, 9, 2, -2, 7, 3);
		repeat (100) send_random_blit();

		// extreme bounds: each surface collapses onto a corner point
		set_bounds(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
		repeat (80) send_random_blit();

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);

		$display("covered %0d blit requests over six surface settings, %0d degenerate",
			items_sent, sb.degenerate_seen);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == items_sent)
			$display("scaled_blit_rect_clipper: match");
		else
			$display("scaled_blit_rect_clipper: mismatch");
		$finish;
	end
endmodule
